// ===== rtl/core/int_to_ascii_radix_format_core_assert.svh =====
// assertion macros used by the radix formatter emitter (itoa_emit)
// no dependencies; checks compile out when SYNTHESIS is defined
`ifndef INT_TO_ASCII_RADIX_FORMAT_CORE_ASSERT_SVH
`define INT_TO_ASCII_RADIX_FORMAT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ITOA_ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("itoa assertion failed");
`define ITOA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa assertion failed");
`else
`define ITOA_ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ITOA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/itoa_pkg.sv =====
// types, constants and the digit character table of the radix formatter
// no dependencies
`default_nettype none

package itoa_pkg;

    localparam int VALUE_W   = 32;
    localparam int KIND_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int BCD_DIGS  = 10;
    localparam int BCD_W     = 4 * BCD_DIGS;
    localparam int CNT_W     = 6;
    localparam int DAB_CNT_W = 5;

    localparam logic [CNT_W-1:0] C_DIGS_DEC = 6'd10;
    localparam logic [CNT_W-1:0] C_DIGS_BIN = 6'd32;
    localparam logic [CNT_W-1:0] C_DIGS_HEX = 6'd8;
    localparam logic [CNT_W-1:0] C_DIGS_OCT = 6'd11;

    localparam logic [CHAR_W-1:0] C_MINUS = 8'h2D;

    localparam logic [CHAR_W-1:0] C_DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef enum logic [KIND_W-1:0] {
        KIND_DEC = 2'd0,
        KIND_BIN = 2'd1,
        KIND_HEX = 2'd2,
        KIND_OCT = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DS_BIN,
        DS_OCT,
        DS_HEX
    } t_dsize;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [BCD_W-1:0] digits;
        logic [CNT_W-1:0] count;
        t_dsize           dsize;
        logic             neg;
    } t_emit_load;

endpackage

`default_nettype wire

// ===== rtl/core/int_to_ascii_radix_format_core.sv =====
// top level of the radix formatter: input handshake, sequencer, sign handling
// depends on itoa_pkg, itoa_dabble and itoa_emit
`default_nettype none

// Formats a 32-bit integer as ASCII, most significant digit first, one character per
// output transaction with tlast on the final one. tuser selects the radix: signed decimal
// (with a leading minus), or unsigned binary, hexadecimal (uppercase) or octal. One item
// is processed at a time. A decimal item first passes through the bit-serial bcd
// converter, one shift per input bit, then a done strobe. The emitter then sends a minus
// sign for a negative decimal and steps through every digit position: 10 for decimal,
// 32 binary, 8 hex, 11 octal, leading zeros included, which are skipped rather than sent.
// The sequencer then returns to idle; output stalls hold the emitter. The next item is
// accepted only after the emitter busy flag clears and the sequencer state returns to idle.
module int_to_ascii_radix_format_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [itoa_pkg::VALUE_W-1:0]        s_axis_tdata,  // value[31:0]
    input  wire logic [itoa_pkg::KIND_W-1:0]         s_axis_tuser,  // kind[1:0]
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [itoa_pkg::CHAR_W-1:0]              m_axis_tdata,  // char_code[7:0]
    output logic                                     m_axis_tlast
);
    import itoa_pkg::*;

    t_state             r_state, n_state;
    logic               r_neg, n_neg;
    logic               accept;
    logic               dab_start;
    logic               dab_done;
    logic [BCD_W-1:0]   dab_bcd;
    logic [VALUE_W-1:0] mag;
    logic               emit_load;
    logic               emit_busy;
    t_emit_load         emit_cfg;
    t_kind              kind;

    assign kind   = t_kind'(s_axis_tuser);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign mag    = s_axis_tdata[VALUE_W-1] ? (VALUE_W'(0) - s_axis_tdata) : s_axis_tdata;

    always_comb begin
        n_state       = r_state;
        n_neg         = r_neg;
        s_axis_tready = 1'b0;
        dab_start     = 1'b0;
        emit_load     = 1'b0;
        emit_cfg      = '{digits: {s_axis_tdata, 8'h00}, count: C_DIGS_HEX,
                          dsize: DS_HEX, neg: 1'b0};
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    unique case (kind)
                        KIND_DEC: begin
                            dab_start = 1'b1;
                            n_neg     = s_axis_tdata[VALUE_W-1];
                            n_state   = ST_DABBLE;
                        end
                        KIND_BIN: begin
                            emit_load      = 1'b1;
                            emit_cfg.count = C_DIGS_BIN;
                            emit_cfg.dsize = DS_BIN;
                            n_state        = ST_EMIT;
                        end
                        KIND_OCT: begin
                            emit_load       = 1'b1;
                            emit_cfg.digits = {1'b0, s_axis_tdata, 7'h00};
                            emit_cfg.count  = C_DIGS_OCT;
                            emit_cfg.dsize  = DS_OCT;
                            n_state         = ST_EMIT;
                        end
                        default: begin
                            emit_load = 1'b1;
                            n_state   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DABBLE: begin
                if (dab_done) begin
                    emit_load       = 1'b1;
                    emit_cfg.digits = dab_bcd;
                    emit_cfg.count  = C_DIGS_DEC;
                    emit_cfg.dsize  = DS_HEX;
                    emit_cfg.neg    = r_neg;
                    n_state         = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_neg <= n_neg;
    end

    itoa_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_bin   (mag),
        .o_done  (dab_done),
        .o_bcd   (dab_bcd)
    );

    itoa_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit_load),
        .i_cfg   (emit_cfg),
        .o_busy  (emit_busy),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/core/itoa_dabble.sv =====
// bit-serial binary to bcd converter, one input bit per cycle (shift and add three)
// depends on itoa_pkg
`default_nettype none

module itoa_dabble (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [itoa_pkg::VALUE_W-1:0] i_bin,
    output logic                              o_done,
    output logic [itoa_pkg::BCD_W-1:0]        o_bcd
);
    import itoa_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DAB_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]   r_bin, n_bin;
    logic [BCD_W-1:0]     r_bcd, n_bcd;
    logic [BCD_W-1:0]     adj;

    always_comb begin
        for (int i = 0; i < BCD_DIGS; i++) begin
            adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                      : r_bcd[4*i +: 4];
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bin  = i_bin;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[VALUE_W-1]};
            n_bin = {r_bin[VALUE_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DAB_CNT_W'(VALUE_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

`default_nettype wire

// ===== rtl/core/itoa_emit.sv =====
// digit emitter: shifts a digit word out msb first, drops leading zeros,
// writes one character per transaction into the output register; depends on itoa_pkg and the assertion macro header
`default_nettype none

`include "int_to_ascii_radix_format_core_assert.svh"

module itoa_emit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire itoa_pkg::t_emit_load        i_cfg,
    output logic                             o_busy,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [itoa_pkg::CHAR_W-1:0]      o_char,
    output logic                             o_last
);
    import itoa_pkg::*;

    logic              r_busy, n_busy;
    logic              r_sign, n_sign;
    logic              r_started, n_started;
    logic [BCD_W-1:0]  r_sr, n_sr;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    t_dsize            r_dsize, n_dsize;
    logic              r_out_valid, n_out_valid;
    logic [CHAR_W-1:0] r_out_char, n_out_char;
    logic              r_out_last, n_out_last;

    logic [3:0]        digit;
    logic [BCD_W-1:0]  sr_shift;
    logic              can_out;
    logic              emit;

    always_comb begin
        unique case (r_dsize)
            DS_BIN: begin
                digit    = {3'b000, r_sr[BCD_W-1]};
                sr_shift = {r_sr[BCD_W-2:0], 1'b0};
            end
            DS_OCT: begin
                digit    = {1'b0, r_sr[BCD_W-1 -: 3]};
                sr_shift = {r_sr[BCD_W-4:0], 3'b000};
            end
            default: begin
                digit    = r_sr[BCD_W-1 -: 4];
                sr_shift = {r_sr[BCD_W-5:0], 4'b0000};
            end
        endcase
    end

    assign can_out = !r_out_valid || i_ready;

    always_comb begin
        n_busy      = r_busy;
        n_sign      = r_sign;
        n_started   = r_started;
        n_sr        = r_sr;
        n_cnt       = r_cnt;
        n_dsize     = r_dsize;
        n_out_valid = r_out_valid && !i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        emit        = 1'b0;
        if (i_load) begin
            n_busy    = 1'b1;
            n_sign    = i_cfg.neg;
            n_started = 1'b0;
            n_sr      = i_cfg.digits;
            n_cnt     = i_cfg.count;
            n_dsize   = i_cfg.dsize;
        end else if (r_busy) begin
            if (r_sign) begin
                if (can_out) begin
                    emit       = 1'b1;
                    n_sign     = 1'b0;
                    n_out_char = C_MINUS;
                    n_out_last = 1'b0;
                end
            end else if (!r_started && digit == 4'd0 && r_cnt != CNT_W'(1)) begin
                // leading zero
                n_sr  = sr_shift;
                n_cnt = r_cnt - 1'b1;
            end else if (can_out) begin
                emit       = 1'b1;
                n_started  = 1'b1;
                n_sr       = sr_shift;
                n_cnt      = r_cnt - 1'b1;
                n_out_char = C_DIGIT_CHARS[digit];
                n_out_last = (r_cnt == CNT_W'(1));
                if (r_cnt == CNT_W'(1)) begin
                    n_busy = 1'b0;
                end
            end
        end
        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_sign      <= 1'b0;
            r_started   <= 1'b0;
            r_cnt       <= '0;
            r_dsize     <= DS_BIN;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_sign      <= n_sign;
            r_started   <= n_started;
            r_cnt       <= n_cnt;
            r_dsize     <= n_dsize;
            r_out_valid <= n_out_valid;
        end
        r_sr       <= n_sr;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_busy  = r_busy;
    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

    `ITOA_ASSERT_ALWAYS(a_load_when_free, i_clk, i_rst_n, !(i_load && r_busy))
    `ITOA_ASSERT_ALWAYS(a_busy_has_digits, i_clk, i_rst_n, !r_busy || r_cnt != '0)
    `ITOA_ASSERT_NEXT(a_last_ends_run, i_clk, i_rst_n, emit && n_out_last, !r_busy)

endmodule

`default_nettype wire

// ===== test/int_to_ascii_radix_format_core_tb.sv =====
`timescale 1ns / 100ps
// testbench for int_to_ascii_radix_format_core: directed and random integers in all four radixes
// depends on itoa_pkg and the core rtl; checks every character against an internal predictor

module int_to_ascii_radix_format_core_tb;
    import itoa_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    localparam int RAND_ITEMS   = 300;
    localparam int MAX_GAP      = 13;
    localparam int HOLD_AT_CHAR = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] ALPHA_CHAR = 8'h41;

    typedef struct {
        t_kind       kind;
        logic [31:0] value;
    } t_fmt_req;

    typedef struct {
        logic [7:0] code;
        logic       last;
    } t_fmt_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // value[31:0]
    logic [1:0]  s_axis_tuser = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // char_code[7:0]
    logic        m_axis_tlast;

    t_fmt_req  pending_reqs[$];
    t_fmt_char expected_chars[$];
    t_fmt_req  offered_req;
    t_fmt_char want_char;

    int src_gap = 0;
    int snk_gap = 0;
    int hold_left = 0;
    int chars_seen = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    logic src_steady = 1'b0;
    logic snk_steady = 1'b0;

    int_to_ascii_radix_format_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // expected string of one request, minus sign if any, most significant digit first
    function automatic void queue_digit_string(input t_fmt_req req);
        logic [31:0] radix;
        logic [31:0] mag;
        logic [3:0]  digs [32];
        int          n;
        t_fmt_char   c;
        mag = req.value;
        n = 0;
        case (req.kind)
            KIND_DEC: radix = 32'd10;
            KIND_BIN: radix = 32'd2;
            KIND_HEX: radix = 32'd16;
            default:  radix = 32'd8;
        endcase
        if (req.kind == KIND_DEC && req.value[31]) begin
            mag = 32'd0 - req.value;
            c.code = MINUS_CHAR;
            c.last = 1'b0;
            expected_chars.push_back(c);
        end
        do begin
            digs[n] = 4'(mag % radix);
            n++;
            mag = mag / radix;
        end while (mag != 32'd0 && n < 32);
        for (int i = n - 1; i >= 0; i--) begin
            if (digs[i] < 4'd10) begin
                c.code = 8'(ZERO_CHAR + digs[i]);
            end else begin
                c.code = 8'(ALPHA_CHAR + digs[i] - 4'd10);
            end
            c.last = (i == 0);
            expected_chars.push_back(c);
        end
    endfunction

    task automatic add_req(input t_kind kind, input logic [31:0] value);
        t_fmt_req r;
        r.kind = kind;
        r.value = value;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [8:0] exp_v,
                                   input logic [8:0] got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch %s at %0t: expected %h, got %h", what, $realtime, exp_v, got_v);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                queue_digit_string(offered_req);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    offered_req = pending_reqs.pop_front();
                    s_axis_tdata <= offered_req.value;
                    s_axis_tuser <= offered_req.kind;
                    s_axis_tvalid <= 1'b1;
                    if ($urandom_range(0, 29) == 0) src_steady = !src_steady;
                    src_gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    report_mismatch("unexpected transaction", 9'h0, {m_axis_tlast, m_axis_tdata});
                end else begin
                    want_char = expected_chars.pop_front();
                    if (m_axis_tdata !== want_char.code) begin
                        report_mismatch("char_code", {1'b0, want_char.code},
                                        {1'b0, m_axis_tdata});
                    end
                    if (m_axis_tlast !== want_char.last) begin
                        report_mismatch("last", {8'h0, want_char.last}, {8'h0, m_axis_tlast});
                    end
                end
                if ($urandom_range(0, 29) == 0) snk_steady = !snk_steady;
                snk_gap = snk_steady ? 0 : $urandom_range(0, MAX_GAP);
                // long hold-off so the core backs up its input
                if (chars_seen == HOLD_AT_CHAR) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("int_to_ascii_radix_format_core_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [31:0] extreme_vals [4];
        logic [31:0] v;
        extreme_vals = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
        for (int k = 0; k < 4; k++) begin
            foreach (extreme_vals[j]) add_req(t_kind'(k), extreme_vals[j]);
        end
        add_req(KIND_DEC, 32'd9);
        add_req(KIND_DEC, 32'd10);
        add_req(KIND_DEC, 32'hFFFF_FFF6);
        add_req(KIND_DEC, 32'd1000000000);
        add_req(KIND_HEX, 32'hABCD_EF09);
        add_req(KIND_BIN, 32'd1);
        add_req(KIND_OCT, 32'd8);
        for (int n = 0; n < RAND_ITEMS; n++) begin
            case ($urandom_range(0, 4))
                0: v = $urandom();
                1: v = $urandom_range(0, 20);
                2: v = 32'd0 - $urandom_range(1, 20);
                3: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
                default: v = $urandom() >> $urandom_range(0, 31);
            endcase
            add_req(t_kind'($urandom_range(0, 3)), v);
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0) begin
            $display("int_to_ascii_radix_format_core_tb: done, clean");
        end else begin
            $display("int_to_ascii_radix_format_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== int_to_ascii_radix_format_core.f =====
+incdir+rtl/core
rtl/core/itoa_pkg.sv
rtl/core/itoa_dabble.sv
rtl/core/itoa_emit.sv
rtl/core/int_to_ascii_radix_format_core.sv
test/int_to_ascii_radix_format_core_tb.sv
